// ===== hdl/rgbe_pkg.sv =====
package rgbe_pkg;

  localparam int unsigned MAX_WIDTH = 8192;
  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
  localparam logic [13:0] POS_MAX = 14'h3FFF;
  localparam logic [13:0] LINE_WIDTH_RST = 14'd1280;
  localparam logic [7:0] RUN_BIAS = 8'd128;

  typedef enum logic [7:0] {
    PH_HDR0  = 8'b0000_0001,
    PH_HDR1  = 8'b0000_0010,
    PH_WHI   = 8'b0000_0100,
    PH_WLO   = 8'b0000_1000,
    PH_COUNT = 8'b0001_0000,
    PH_RUN   = 8'b0010_0000,
    PH_LIT   = 8'b0100_0000,
    PH_READ  = 8'b1000_0000
  } phase_t;

  // store write request from the decoder
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        lane;
    logic [7:0]        data;
  } st_wr_t;

  // mantissa m, exponent e -> m * 2^(e-128) as ieee single
  function automatic logic [31:0] to_float(input logic [7:0] m, input logic [7:0] e);
    logic [2:0]  k;
    logic signed [10:0] biased;
    logic [31:0] res;
    logic [7:0]  sh;
    k = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (m[i]) k = 3'(i);
    end
    biased = 11'(signed'({8'd0, k})) + 11'(signed'({3'd0, e})) - 11'sd1;
    sh = 8'd0;
    if (m == 8'd0) begin
      res = 32'd0;
    end else if (biased >= 11'sd255) begin
      res = 32'h7F80_0000;
    end else if (biased >= 11'sd1) begin
      res = {1'b0, biased[7:0], 23'(({15'd0, m} << (5'd23 - 5'(k))))};
    end else begin
      sh = e + 8'd21;
      res = {24'd0, m} << sh[4:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/rgbe_ram.sv =====
module rgbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rgbe_conv.sv =====
module rgbe_conv (
  input  logic [31:0] entry,
  output logic [31:0] red_bits,
  output logic [31:0] green_bits,
  output logic [31:0] blue_bits
);

  // exponent byte shared by all three colours
  assign red_bits   = rgbe_pkg::to_float(entry[7:0],   entry[31:24]);
  assign green_bits = rgbe_pkg::to_float(entry[15:8],  entry[31:24]);
  assign blue_bits  = rgbe_pkg::to_float(entry[23:16], entry[31:24]);

endmodule

// ===== hdl/rgbe_rle_scanline_decoder_top.sv =====
// channel | ports                                 | dir
// in      | start, busy, in_cmd/stream_byte/pixel_index | in (busy out)
// out     | out_valid, out_* fields               | out, one cycle strobe
// cfg     | cfg_we, cfg_line_width                | in
//
// a header or count byte is taken alone, a literal byte as a read then a merged write,
// a run value byte as a read then one write per decoded byte, a pixel read as a store
// read then the result, as the line store read is registered; busy covers the extra cycles
// reset: synchronous active low, clears decode state and sets line_width to 1280
// stalls: the receiver cannot stall; results are registered and appear after the last
// store access of the beat
module rgbe_rle_scanline_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [7:0]  in_stream_byte,
  input  logic [12:0] in_pixel_index,
  input  logic        cfg_we,
  input  logic [13:0] cfg_line_width,
  output logic        out_valid,
  output logic        out_line_complete,
  output logic        out_width_error,
  output logic        out_index_error,
  output logic [31:0] out_red_bits,
  output logic [31:0] out_green_bits,
  output logic [31:0] out_blue_bits
);

  localparam int unsigned AW = rgbe_pkg::ADDR_W;

  rgbe_pkg::phase_t ph_r, ph_nxt;
  // separate flags for the multi-cycle activities
  logic        run_act_r, run_act_nxt;   // run burst in progress
  logic        rd_act_r, rd_act_nxt;     // read pending store data
  logic        rmw_r, rmw_nxt;           // single byte read-modify-write pending
  logic [13:0] lw_r;
  logic [7:0]  whi_r, whi_nxt;
  logic [1:0]  plane_r, plane_nxt;
  logic [13:0] pos_r, pos_nxt;
  logic [7:0]  seg_r, seg_nxt;
  logic [7:0]  val_r, val_nxt;

  logic        ov_r, ov_nxt;
  logic        olc_r, olc_nxt, owe_r, owe_nxt, oie_r, oie_nxt;
  logic [31:0] ored_r, ogrn_r, oblu_r;

  logic [AW-1:0] raddr;
  logic [31:0]   rdata, wdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   cr, cg, cb;
  logic          acc;

  // last written entry forwarded so back-to-back writes of one entry see it
  logic [31:0]   fwd_r;
  logic          fwd_v_r;
  logic [AW-1:0] fwd_a_r;
  logic [31:0]   base;

  assign busy = run_act_r | rd_act_r | rmw_r;
  assign acc  = start & ~busy;

  rgbe_ram #(.WIDTH(32), .DEPTH(rgbe_pkg::MAX_WIDTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  rgbe_conv u_conv (.entry(rdata), .red_bits(cr), .green_bits(cg), .blue_bits(cb));

  assign base = (fwd_v_r && fwd_a_r == pos_r[AW-1:0]) ? fwd_r : rdata;

  // write is the merge of one lane into the entry read the cycle before
  always_comb begin
    wdata = base;
    unique case (plane_r)
      2'd0: wdata[7:0]   = val_r;
      2'd1: wdata[15:8]  = val_r;
      2'd2: wdata[23:16] = val_r;
      2'd3: wdata[31:24] = val_r;
      default: wdata = base;
    endcase
  end

  logic in_range;
  assign in_range = (pos_r < lw_r) && ({1'b0, pos_r} < 15'(rgbe_pkg::MAX_WIDTH));
  assign waddr    = pos_r[AW-1:0];

  // segment end handling, returns complete flag via nxt values
  logic [13:0] pos_adv;
  assign pos_adv = (pos_r < rgbe_pkg::POS_MAX) ? pos_r + 14'd1 : pos_r;

  always_comb begin
    ph_nxt = ph_r; run_act_nxt = run_act_r; rd_act_nxt = 1'b0; rmw_nxt = 1'b0;
    whi_nxt = whi_r; plane_nxt = plane_r; pos_nxt = pos_r; seg_nxt = seg_r;
    val_nxt = val_r;
    ov_nxt = 1'b0; olc_nxt = 1'b0; owe_nxt = 1'b0; oie_nxt = 1'b0;
    we = 1'b0;
    raddr = pos_r[AW-1:0];
    if (rd_act_r) begin
      ov_nxt = 1'b1;
    end else if (run_act_r || rmw_r) begin
      // store write for the entry read last cycle
      we = in_range;
      pos_nxt = pos_adv;
      raddr = pos_adv[AW-1:0];
      if (run_act_r) seg_nxt = seg_r - 8'd1;
      if ((run_act_r && seg_r == 8'd1) || (rmw_r && seg_r == 8'd0)) begin
        run_act_nxt = 1'b0;
        seg_nxt = 8'd0;
        ov_nxt = 1'b1;
        ph_nxt = rgbe_pkg::PH_COUNT;
        if (pos_adv >= lw_r) begin
          pos_nxt = 14'd0;
          if (plane_r == 2'd3) begin
            plane_nxt = 2'd0;
            ph_nxt = rgbe_pkg::PH_HDR0;
            olc_nxt = 1'b1;
          end else begin
            plane_nxt = plane_r + 2'd1;
          end
        end
      end else if (rmw_r) begin
        ov_nxt = 1'b1;
        ph_nxt = rgbe_pkg::PH_LIT;
      end
    end else if (acc) begin
      if (in_cmd) begin
        if ({1'b0, in_pixel_index} >= lw_r) begin
          ov_nxt = 1'b1; oie_nxt = 1'b1;
        end else begin
          raddr = in_pixel_index[AW-1:0];
          rd_act_nxt = 1'b1;
        end
      end else begin
        ov_nxt = 1'b1;
        unique case (ph_r)
          rgbe_pkg::PH_HDR1: ph_nxt = rgbe_pkg::PH_WHI;
          rgbe_pkg::PH_WHI: begin
            whi_nxt = in_stream_byte; ph_nxt = rgbe_pkg::PH_WLO;
          end
          rgbe_pkg::PH_WLO: begin
            if ({whi_r, in_stream_byte} != {2'b00, lw_r}) begin
              owe_nxt = 1'b1; ph_nxt = rgbe_pkg::PH_HDR0;
            end else begin
              plane_nxt = 2'd0; pos_nxt = 14'd0; seg_nxt = 8'd0;
              ph_nxt = rgbe_pkg::PH_COUNT;
              if (lw_r == 14'd0) begin
                olc_nxt = 1'b1; ph_nxt = rgbe_pkg::PH_HDR0;
              end
            end
          end
          rgbe_pkg::PH_COUNT: begin
            if (in_stream_byte > rgbe_pkg::RUN_BIAS) begin
              seg_nxt = in_stream_byte - rgbe_pkg::RUN_BIAS; ph_nxt = rgbe_pkg::PH_RUN;
            end else if (in_stream_byte != 8'd0) begin
              seg_nxt = in_stream_byte; ph_nxt = rgbe_pkg::PH_LIT;
            end
          end
          rgbe_pkg::PH_RUN: begin
            // result comes at the end of the burst
            ov_nxt = 1'b0; val_nxt = in_stream_byte;
            run_act_nxt = 1'b1; ph_nxt = rgbe_pkg::PH_READ;
          end
          rgbe_pkg::PH_LIT: begin
            ov_nxt = 1'b0; val_nxt = in_stream_byte;
            seg_nxt = seg_r - 8'd1;
            rmw_nxt = 1'b1; ph_nxt = rgbe_pkg::PH_READ;
          end
          default: ph_nxt = rgbe_pkg::PH_HDR1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= rgbe_pkg::PH_HDR0; run_act_r <= 1'b0; rd_act_r <= 1'b0; rmw_r <= 1'b0;
      lw_r <= rgbe_pkg::LINE_WIDTH_RST; whi_r <= 8'd0; plane_r <= 2'd0;
      pos_r <= 14'd0; seg_r <= 8'd0; ov_r <= 1'b0; fwd_v_r <= 1'b0;
      olc_r <= 1'b0; owe_r <= 1'b0; oie_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; run_act_r <= run_act_nxt; rd_act_r <= rd_act_nxt; rmw_r <= rmw_nxt;
      if (cfg_we) lw_r <= cfg_line_width;
      whi_r <= whi_nxt; plane_r <= plane_nxt; pos_r <= pos_nxt; seg_r <= seg_nxt;
      ov_r <= ov_nxt; olc_r <= olc_nxt; owe_r <= owe_nxt; oie_r <= oie_nxt;
      fwd_v_r <= we;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    fwd_r <= wdata;
    fwd_a_r <= waddr;
    ored_r <= rd_act_r ? cr : 32'd0;
    ogrn_r <= rd_act_r ? cg : 32'd0;
    oblu_r <= rd_act_r ? cb : 32'd0;
  end

  assign out_valid         = ov_r;
  assign out_line_complete = olc_r;
  assign out_width_error   = owe_r;
  assign out_index_error   = oie_r;
  assign out_red_bits      = ored_r;
  assign out_green_bits    = ogrn_r;
  assign out_blue_bits     = oblu_r;

`ifndef SYNTH
  a_one_activity: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({run_act_r, rd_act_r, rmw_r})) else $error("overlapping store activities");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !acc) else $error("accepted while busy");
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    rd_act_r |=> out_valid) else $error("read gave no result");
`endif

endmodule

// ===== tb/rgbe_rle_scanline_decoder_top_tb.sv =====
module rgbe_rle_scanline_decoder_top_tb;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned RANDOM_ITEMS = 1200;

  // one decoded beat as the block should present it
  typedef struct {
    bit        line_complete;
    bit        width_error;
    bit        index_error;
    bit [31:0] red;
    bit [31:0] green;
    bit [31:0] blue;
  } decoded_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_cmd = 1'b0;
  logic [7:0]  in_stream_byte = 8'd0;
  logic [12:0] in_pixel_index = 13'd0;
  logic        cfg_we = 1'b0;
  logic [13:0] cfg_line_width = 14'd0;
  logic        out_valid;
  logic        out_line_complete;
  logic        out_width_error;
  logic        out_index_error;
  logic [31:0] out_red_bits;
  logic [31:0] out_green_bits;
  logic [31:0] out_blue_bits;

  rgbe_rle_scanline_decoder_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_stream_byte    (in_stream_byte),
    .in_pixel_index    (in_pixel_index),
    .cfg_we            (cfg_we),
    .cfg_line_width    (cfg_line_width),
    .out_valid         (out_valid),
    .out_line_complete (out_line_complete),
    .out_width_error   (out_width_error),
    .out_index_error   (out_index_error),
    .out_red_bits      (out_red_bits),
    .out_green_bits    (out_green_bits),
    .out_blue_bits     (out_blue_bits)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow decoder: our own copy of line width, decode state and line store
  // ---------------------------------------------------------------------------
  bit [13:0]        line_width_sh;
  rgbe_pkg::phase_t phase_sh;
  bit [7:0]         width_hi_sh;
  bit [1:0]         plane_sh;
  bit [13:0]        write_pos_sh;
  bit [7:0]         seg_left_sh;
  bit [31:0]        store_sh [rgbe_pkg::MAX_WIDTH];
  // a read is legal only once all four lanes are set
  bit [3:0]         lanes_written [rgbe_pkg::MAX_WIDTH];

  decoded_beat_t expected_beats[$];

  int unsigned idle_pct;
  int unsigned items_sent;
  int unsigned lines_done;
  int unsigned width_errors;
  int unsigned pixel_reads;
  int unsigned bad_reads;
  int unsigned mismatches;
  int unsigned cycles;

  // m * 2^(e-128) as an ieee single, exact
  function automatic bit [31:0] rgbe_to_single(bit [7:0] mant, bit [7:0] expo);
    int msb;
    int biased;
    bit [31:0] wide;
    if (mant == 8'd0) return 32'd0;
    msb = 0;
    for (int i = 0; i < 8; i++) if (mant[i]) msb = i;
    biased = msb + int'(expo) - 1;
    if (biased >= 255) return 32'h7F80_0000;
    if (biased >= 1) begin
      wide = 32'(mant) << (23 - msb);
      return {1'b0, biased[7:0], wide[22:0]};
    end
    // subnormal: mantissa lands at bit position expo+21, never past bit 22
    return 32'(mant) << (int'(expo) + 21);
  endfunction

  task automatic store_decoded(bit [7:0] value);
    if (write_pos_sh < line_width_sh && write_pos_sh < rgbe_pkg::MAX_WIDTH) begin
      store_sh[write_pos_sh[12:0]][plane_sh*8 +: 8] = value;
      lanes_written[write_pos_sh[12:0]][plane_sh] = 1'b1;
    end
    if (write_pos_sh < rgbe_pkg::POS_MAX) write_pos_sh++;
  endtask

  // segment finished; returns 1 when the fourth plane is through
  function automatic bit close_segment();
    phase_sh = rgbe_pkg::PH_COUNT;
    if (write_pos_sh < line_width_sh) return 1'b0;
    write_pos_sh = '0;
    if (plane_sh == 2'd3) begin
      plane_sh = 2'd0;
      phase_sh = rgbe_pkg::PH_HDR0;
      return 1'b1;
    end
    plane_sh++;
    return 1'b0;
  endfunction

  task automatic decode_beat(bit cmd, bit [7:0] b, bit [12:0] idx, output decoded_beat_t r);
    bit [31:0] entry;
    r = '{default: '0};
    if (cmd) begin
      if (idx >= line_width_sh) begin
        r.index_error = 1'b1;
      end else begin
        entry = store_sh[idx];
        r.red   = rgbe_to_single(entry[7:0],   entry[31:24]);
        r.green = rgbe_to_single(entry[15:8],  entry[31:24]);
        r.blue  = rgbe_to_single(entry[23:16], entry[31:24]);
      end
      return;
    end
    case (phase_sh)
      rgbe_pkg::PH_HDR1: phase_sh = rgbe_pkg::PH_WHI;
      rgbe_pkg::PH_WHI: begin
        width_hi_sh = b;
        phase_sh = rgbe_pkg::PH_WLO;
      end
      rgbe_pkg::PH_WLO: begin
        if ({width_hi_sh, b} != {2'b00, line_width_sh}) begin
          r.width_error = 1'b1;
          phase_sh = rgbe_pkg::PH_HDR0;
        end else begin
          plane_sh = '0;
          write_pos_sh = '0;
          seg_left_sh = '0;
          phase_sh = rgbe_pkg::PH_COUNT;
          if (line_width_sh == '0) begin
            r.line_complete = 1'b1;
            phase_sh = rgbe_pkg::PH_HDR0;
          end
        end
      end
      rgbe_pkg::PH_COUNT: begin
        if (b > rgbe_pkg::RUN_BIAS) begin
          seg_left_sh = b - rgbe_pkg::RUN_BIAS;
          phase_sh = rgbe_pkg::PH_RUN;
        end else if (b != 8'd0) begin
          seg_left_sh = b;
          phase_sh = rgbe_pkg::PH_LIT;
        end
      end
      rgbe_pkg::PH_RUN: begin
        repeat (seg_left_sh) store_decoded(b);
        seg_left_sh = '0;
        r.line_complete = close_segment();
      end
      rgbe_pkg::PH_LIT: begin
        store_decoded(b);
        if (seg_left_sh != 0) seg_left_sh--;
        if (seg_left_sh == 0) r.line_complete = close_segment();
      end
      default: phase_sh = rgbe_pkg::PH_HDR1;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // beat driver: holds start until the block takes the beat
  // ---------------------------------------------------------------------------
  task automatic send_beat(bit cmd, bit [7:0] b, bit [12:0] idx);
    decoded_beat_t r;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_stream_byte <= b;
    in_pixel_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    decode_beat(cmd, b, idx, r);
    expected_beats.push_back(r);
    items_sent++;
    if (r.line_complete) lines_done++;
    if (r.width_error) width_errors++;
    if (cmd) begin
      pixel_reads++;
      if (r.index_error) bad_reads++;
    end
  endtask

  // drop start and let everything drain
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_line_width(bit [13:0] w);
    drain();
    cfg_we         <= 1'b1;
    cfg_line_width <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    line_width_sh = w;
    @(posedge clk);
  endtask

  // pixel read that never touches an entry with unset lanes
  task automatic read_pixel(bit [12:0] idx);
    if (idx < line_width_sh && lanes_written[idx] != 4'hF) return;
    send_beat(1'b1, 8'($urandom), idx);
  endtask

  task automatic read_some_pixels(int n);
    int lim;
    lim = (line_width_sh > rgbe_pkg::MAX_WIDTH) ? rgbe_pkg::MAX_WIDTH : int'(line_width_sh);
    repeat (n) begin
      if (lim == 0 || $urandom_range(4) == 0) read_pixel(13'($urandom));
      else read_pixel(13'($urandom_range(lim - 1)));
    end
  endtask

  // encoded line with random segments; the shadow state says when it is through
  task automatic send_line(bit bad_width, int run_pct, int max_lit);
    bit [15:0] w;
    int cnt;
    int pick;
    w = {2'b00, line_width_sh};
    if (bad_width) w = w ^ 16'($urandom_range(1, 16'hFFFF));
    send_beat(1'b0, 8'($urandom), '0);
    send_beat(1'b0, 8'($urandom), '0);
    send_beat(1'b0, w[15:8], '0);
    send_beat(1'b0, w[7:0], '0);
    while (phase_sh != rgbe_pkg::PH_HDR0) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_beat(1'b0, 8'd0, '0);
      end else if (pick < 3 + run_pct) begin
        send_beat(1'b0, 8'($urandom_range(129, 255)), '0);
        send_beat(1'b0, 8'($urandom), '0);
      end else begin
        cnt = $urandom_range(1, max_lit);
        send_beat(1'b0, 8'(cnt), '0);
        repeat (cnt) begin
          // a stray read mid-segment must not disturb decoding
          if ($urandom_range(19) == 0) read_some_pixels(1);
          send_beat(1'b0, 8'($urandom), '0);
        end
      end
    end
  endtask

  // header then runs of 127 copies until the line is through
  task automatic send_long_runs_line();
    bit [15:0] w;
    w = {2'b00, line_width_sh};
    send_beat(1'b0, 8'h02, '0);
    send_beat(1'b0, 8'h02, '0);
    send_beat(1'b0, w[15:8], '0);
    send_beat(1'b0, w[7:0], '0);
    while (phase_sh != rgbe_pkg::PH_HDR0) begin
      send_beat(1'b0, 8'd255, '0);
      send_beat(1'b0, 8'($urandom), '0);
    end
  endtask

  // literal line of exactly four pixels per plane, values given per plane
  task automatic send_literal_line(bit [31:0] plane_bytes [4]);
    send_beat(1'b0, 8'h02, '0);
    send_beat(1'b0, 8'h02, '0);
    send_beat(1'b0, 8'h00, '0);
    send_beat(1'b0, 8'h04, '0);
    for (int p = 0; p < 4; p++) begin
      send_beat(1'b0, 8'd4, '0);
      for (int i = 0; i < 4; i++) send_beat(1'b0, plane_bytes[p][i*8 +: 8], '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checker: every strobe must match the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    decoded_beat_t e;
    if (rst_n && out_valid) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        e = expected_beats.pop_front();
        if (out_line_complete !== e.line_complete || out_width_error !== e.width_error ||
            out_index_error !== e.index_error || out_red_bits !== e.red ||
            out_green_bits !== e.green || out_blue_bits !== e.blue) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch cycle %0d: exp done=%b werr=%b ierr=%b r=%h g=%h b=%h",
                     cycles, e.line_complete, e.width_error, e.index_error,
                     e.red, e.green, e.blue);
            $display("  got done=%b werr=%b ierr=%b r=%h g=%h b=%h",
                     out_line_complete, out_width_error, out_index_error,
                     out_red_bits, out_green_bits, out_blue_bits);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // reset width of 1280, only runs and empty count bytes
  task automatic test_reset_width();
    send_line(1'b0, 97, 4);
    read_some_pixels(3);
    read_pixel(13'd1279);
    read_pixel(13'd1280);
  endtask

  // zero mantissa, overflow to inf, subnormals and the largest exponent
  task automatic test_special_values();
    bit [31:0] planes [4];
    write_line_width(14'd4);
    planes[0] = 32'h80_FF_01_00;   // red
    planes[1] = 32'h01_7F_FF_00;   // green
    planes[2] = 32'hFF_00_80_FF;   // blue
    planes[3] = 32'h01_FF_00_80;   // exponent: 128, 0, 255, 1
    send_literal_line(planes);
    for (int i = 0; i < 4; i++) read_pixel(13'(i));
    read_pixel(13'd4);
    read_pixel(13'd8191);
  endtask

  // header width that does not match, then noise from the header state
  task automatic test_width_error();
    send_line(1'b1, 50, 8);
    send_beat(1'b0, 8'hFF, '0);
    send_beat(1'b0, 8'hFF, '0);
    send_beat(1'b0, 8'hFF, '0);
    send_beat(1'b0, 8'hFF, '0);
  endtask

  // zero width: the line completes on the last header byte
  task automatic test_zero_width();
    write_line_width(14'd0);
    send_line(1'b0, 50, 8);
    read_pixel(13'd0);
  endtask

  // width register changed while a line is half decoded
  task automatic test_width_change_mid_line();
    write_line_width(14'd8);
    send_beat(1'b0, 8'h02, '0);
    send_beat(1'b0, 8'h02, '0);
    send_beat(1'b0, 8'h00, '0);
    send_beat(1'b0, 8'h08, '0);
    send_beat(1'b0, 8'd131, '0);
    send_beat(1'b0, 8'h5A, '0);
    write_line_width(14'd5);
    while (phase_sh != rgbe_pkg::PH_HDR0) begin
      send_beat(1'b0, 8'd130, '0);
      send_beat(1'b0, 8'($urandom), '0);
    end
    read_some_pixels(4);
  endtask

  // width past the store size: the whole store is filled, the tail is dropped
  task automatic test_max_width();
    write_line_width(14'd8300);
    send_long_runs_line();
    read_pixel(13'd8191);
    read_pixel(13'd0);
    read_pixel(13'd4095);
  endtask

  // mostly well-formed lines of small widths, some broken ones and noise
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned stop_at;
    int pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        case ($urandom_range(3))
          0: write_line_width(14'd1);
          1: write_line_width(14'($urandom_range(2, 48)));
          2: write_line_width(14'($urandom_range(1, 12)));
          default: write_line_width(14'($urandom_range(49, 300)));
        endcase
      end else if (pick < 70) begin
        send_line(1'b0, 45, 16);
      end else if (pick < 78) begin
        send_line(1'b1, 45, 16);
      end else if (pick < 95) begin
        read_some_pixels($urandom_range(1, 8));
      end else begin
        // stray bytes, possibly leaving a half-read header behind
        repeat ($urandom_range(1, 3)) send_beat(1'b0, 8'($urandom), '0);
      end
    end
  endtask

  initial begin
    line_width_sh = rgbe_pkg::LINE_WIDTH_RST;
    phase_sh = rgbe_pkg::PH_HDR0;
    idle_pct = 8;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_width();
    test_special_values();
    test_width_error();
    test_zero_width();
    test_width_change_mid_line();
    test_max_width();

    // sender idling light, then heavy, then none at all
    write_line_width(14'd16);
    idle_pct = 8;
    test_random_traffic(RANDOM_ITEMS / 3);
    idle_pct = 48;
    test_random_traffic(RANDOM_ITEMS / 3);
    idle_pct = 0;
    test_random_traffic(RANDOM_ITEMS / 3);

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d beats: %0d lines decoded, %0d header width errors", items_sent,
             lines_done, width_errors);
    $display("pixel reads %0d (%0d out of range), mismatches %0d, %0d left waiting",
             pixel_reads, bad_reads, mismatches, expected_beats.size());
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
